// ----- hdl/vfra_pkg.sv -----
`default_nettype none
package vfra_pkg;

  localparam int CNT_W = 9;   // counts, indexes and starts inside a pool
  localparam int VFC_W = 7;   // function count

  localparam logic POOL_Q = 1'b0;
  localparam logic POOL_V = 1'b1;

  localparam logic CMD_CREATE  = 1'b0;
  localparam logic CMD_DESTROY = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXISTS    = 3'd1;
  localparam logic [2:0] ST_LIMIT     = 3'd2;
  localparam logic [2:0] ST_NO_QUEUE  = 3'd3;
  localparam logic [2:0] ST_NO_VECTOR = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic [2:0] CFG_TOTAL_Q  = 3'd0;
  localparam logic [2:0] CFG_TOTAL_V  = 3'd1;
  localparam logic [2:0] CFG_RSV_Q    = 3'd2;
  localparam logic [2:0] CFG_RSV_V    = 3'd3;
  localparam logic [2:0] CFG_MAX_VFS  = 3'd4;

  typedef enum logic [1:0] {
    OP_FIND,
    OP_MARK,
    OP_COUNT
  } eng_op_t;

  typedef struct packed {
    eng_op_t op;
    logic    pool;
    logic    val;
  } eng_cmd_t;

  typedef enum logic [1:0] {
    E_CLEAR,
    E_IDLE,
    E_SCAN,
    E_MARK
  } eng_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_QFIND,
    S_VFIND,
    S_QMARK,
    S_VMARK,
    S_QCOUNT,
    S_VCOUNT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] qb;
    logic [CNT_W-1:0] ql;
    logic [CNT_W-1:0] vb;
    logic [CNT_W-1:0] vl;
  } vf_entry_t;

endpackage
`default_nettype wire

// ----- hdl/vfra_in_if.sv -----
`default_nettype none
interface vfra_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [5:0] vf_number;
  logic [8:0] requested_queues;
  logic [8:0] requested_vectors;

  modport source (output valid, command, vf_number, requested_queues, requested_vectors,
                  input ready);
  modport sink (input valid, command, vf_number, requested_queues, requested_vectors,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/vfra_out_if.sv -----
`default_nettype none
interface vfra_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] first_queue;
  logic [7:0] first_vector;
  logic [8:0] queues_free;
  logic [8:0] vectors_free;
  logic [6:0] vfs_created;

  modport source (output valid, status, first_queue, first_vector, queues_free,
                  vectors_free, vfs_created, input ready);
  modport sink (input valid, status, first_queue, first_vector, queues_free,
                vectors_free, vfs_created, output ready);
endinterface
`default_nettype wire

// ----- hdl/vf_contiguous_range_allocator.sv -----
`default_nettype none
// Contiguous queue/vector range allocator for virtual functions. A create request
// takes the first free run of the requested length in the queue pool, then in the
// vector pool (first fit, entries below the reserve count as busy), marks both busy
// and records them; a destroy request frees the recorded runs. Every request gives
// one result with status, run starts and the free counts after the request. One
// shared bitmap engine does all the work one entry per cycle; a successful create scans
// each pool up to the run end and marks both runs, a destroy marks both runs free, and
// every request ends with a free count of each pool. One request is in flight at a
// time. After reset the engine clears both bitmaps before the first request is
// accepted; configuration writes are taken throughout.
module vf_contiguous_range_allocator #(
  parameter int QUEUE_POOL  = 256,
  parameter int VECTOR_POOL = 256,
  parameter int VF_SLOTS    = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  vfra_in_if.sink         in_req,
  vfra_out_if.source      out_rsp,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_index,
  input  wire logic [8:0] cfg_wdata
);

  localparam int W  = vfra_pkg::CNT_W;
  localparam int VW = (VF_SLOTS > 1) ? $clog2(VF_SLOTS) : 1;

  // configuration
  logic [8:0] total_q_r, total_v_r, rsv_q_r, rsv_v_r;
  logic [6:0] max_vfs_r;

  // request context
  vfra_pkg::state_t state_r, state_nxt;
  logic         cmd_r, cmd_nxt;
  logic [5:0]   vf_r, vf_nxt;
  logic [W-1:0] nq_r, nq_nxt, nv_r, nv_nxt;
  logic [2:0]   status_r, status_nxt;
  logic [W-1:0] fq_r, fq_nxt, fv_r, fv_nxt, qfree_r, qfree_nxt;
  logic [W-1:0] vfree_r, vfree_nxt;
  logic [6:0]   total_r, total_nxt;
  logic [VF_SLOTS-1:0] present_r, present_nxt;
  logic         issued_r, issued_nxt;

  // result register
  logic         ov_r, ov_nxt;
  logic [2:0]   o_status_r, o_status_nxt;
  logic [7:0]   o_fq_r, o_fq_nxt, o_fv_r, o_fv_nxt;
  logic [8:0]   o_qf_r, o_qf_nxt, o_vf_r, o_vf_nxt;
  logic [6:0]   o_tot_r, o_tot_nxt;

  // per-function record store
  vfra_pkg::vf_entry_t store [VF_SLOTS];
  vfra_pkg::vf_entry_t st_rd_r, st_wr;
  logic st_we;
  logic [VW-1:0] vidx;
  logic [VW-1:0] rd_idx;
  logic in_range;

  // engine hookup
  vfra_pkg::eng_cmd_t ecmd;
  logic eng_start, eng_rdy, eng_done, eng_found;
  logic [W-1:0] e_used, e_res, e_idx, e_cnt;
  logic [W-1:0] used_q, used_v;
  logic eng_state;

  assign used_q   = (32'(total_q_r) > QUEUE_POOL)  ? W'(QUEUE_POOL)  : total_q_r;
  assign used_v   = (32'(total_v_r) > VECTOR_POOL) ? W'(VECTOR_POOL) : total_v_r;
  assign vidx     = VW'(vf_r);
  // store is read at the incoming function number, so the record is there in S_CHECK
  assign rd_idx   = VW'(vf_nxt);
  assign in_range = (32'(vf_r) < VF_SLOTS);

  assign in_req.ready         = (state_r == vfra_pkg::S_IDLE) && eng_rdy;
  assign out_rsp.valid        = ov_r;
  assign out_rsp.status       = o_status_r;
  assign out_rsp.first_queue  = o_fq_r;
  assign out_rsp.first_vector = o_fv_r;
  assign out_rsp.queues_free  = o_qf_r;
  assign out_rsp.vectors_free = o_vf_r;
  assign out_rsp.vfs_created  = o_tot_r;

  // engine command follows the state
  always_comb begin
    ecmd.op   = vfra_pkg::OP_COUNT;
    ecmd.pool = vfra_pkg::POOL_Q;
    ecmd.val  = (cmd_r == vfra_pkg::CMD_CREATE);
    eng_state = 1'b1;
    case (state_r)
      vfra_pkg::S_QFIND:  ecmd.op = vfra_pkg::OP_FIND;
      vfra_pkg::S_VFIND: begin
        ecmd.op   = vfra_pkg::OP_FIND;
        ecmd.pool = vfra_pkg::POOL_V;
      end
      vfra_pkg::S_QMARK:  ecmd.op = vfra_pkg::OP_MARK;
      vfra_pkg::S_VMARK: begin
        ecmd.op   = vfra_pkg::OP_MARK;
        ecmd.pool = vfra_pkg::POOL_V;
      end
      vfra_pkg::S_QCOUNT: ecmd.op = vfra_pkg::OP_COUNT;
      vfra_pkg::S_VCOUNT: ecmd.pool = vfra_pkg::POOL_V;
      default: eng_state = 1'b0;
    endcase
  end

  assign e_used    = (ecmd.pool == vfra_pkg::POOL_V) ? used_v : used_q;
  assign e_res     = (ecmd.pool == vfra_pkg::POOL_V) ? rsv_v_r : rsv_q_r;
  assign eng_start = eng_state && !issued_r;

  vfra_engine #(
    .QUEUE_POOL  (QUEUE_POOL),
    .VECTOR_POOL (VECTOR_POOL)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (eng_start),
    .cmd       (ecmd),
    .used      (e_used),
    .reserved  (e_res),
    .len       ((ecmd.pool == vfra_pkg::POOL_V) ? nv_r : nq_r),
    .start_idx ((ecmd.pool == vfra_pkg::POOL_V) ? fv_r : fq_r),
    .rdy       (eng_rdy),
    .done      (eng_done),
    .found     (eng_found),
    .res_idx   (e_idx),
    .res_cnt   (e_cnt)
  );

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    vf_nxt      = vf_r;
    nq_nxt      = nq_r;
    nv_nxt      = nv_r;
    status_nxt  = status_r;
    fq_nxt      = fq_r;
    fv_nxt      = fv_r;
    qfree_nxt   = qfree_r;
    vfree_nxt   = vfree_r;
    total_nxt   = total_r;
    present_nxt = present_r;
    issued_nxt  = issued_r;
    st_we       = 1'b0;
    st_wr       = '{qb: fq_r, ql: nq_r, vb: e_idx, vl: nv_r};
    ov_nxt       = ov_r && !out_rsp.ready;
    o_status_nxt = o_status_r;
    o_fq_nxt     = o_fq_r;
    o_fv_nxt     = o_fv_r;
    o_qf_nxt     = o_qf_r;
    o_vf_nxt     = o_vf_r;
    o_tot_nxt    = o_tot_r;

    if (eng_start) issued_nxt = 1'b1;
    if (eng_done)  issued_nxt = 1'b0;

    case (state_r)
      vfra_pkg::S_IDLE: begin
        if (in_req.valid && in_req.ready) begin
          cmd_nxt    = in_req.command;
          vf_nxt     = in_req.vf_number;
          nq_nxt     = in_req.requested_queues;
          nv_nxt     = in_req.requested_vectors;
          status_nxt = vfra_pkg::ST_OK;
          fq_nxt     = '0;
          fv_nxt     = '0;
          state_nxt  = vfra_pkg::S_CHECK;
        end
      end
      vfra_pkg::S_CHECK: begin
        // store read of vf_r is valid here
        state_nxt = vfra_pkg::S_QCOUNT;
        if (cmd_r == vfra_pkg::CMD_CREATE) begin
          if (in_range && present_r[vidx]) begin
            status_nxt = vfra_pkg::ST_EXISTS;
          end else if (!in_range || total_r >= max_vfs_r || 32'(total_r) >= VF_SLOTS) begin
            status_nxt = vfra_pkg::ST_LIMIT;
          end else begin
            state_nxt = vfra_pkg::S_QFIND;
          end
        end else begin
          if (!in_range || !present_r[vidx]) begin
            status_nxt = vfra_pkg::ST_NOT_FOUND;
          end else begin
            fq_nxt = st_rd_r.qb;
            nq_nxt = st_rd_r.ql;
            fv_nxt = st_rd_r.vb;
            nv_nxt = st_rd_r.vl;
            present_nxt[vidx] = 1'b0;
            if (total_r != '0) total_nxt = total_r - 7'd1;
            state_nxt = vfra_pkg::S_QMARK;
          end
        end
      end
      vfra_pkg::S_QFIND: begin
        if (eng_done) begin
          if (eng_found) begin
            fq_nxt    = e_idx;
            state_nxt = vfra_pkg::S_VFIND;
          end else begin
            status_nxt = vfra_pkg::ST_NO_QUEUE;
            state_nxt  = vfra_pkg::S_QCOUNT;
          end
        end
      end
      vfra_pkg::S_VFIND: begin
        if (eng_done) begin
          if (eng_found) begin
            // commit the new function
            fv_nxt = e_idx;
            st_we  = 1'b1;
            present_nxt[vidx] = 1'b1;
            total_nxt = total_r + 7'd1;
            state_nxt = vfra_pkg::S_QMARK;
          end else begin
            status_nxt = vfra_pkg::ST_NO_VECTOR;
            fq_nxt     = '0;
            state_nxt  = vfra_pkg::S_QCOUNT;
          end
        end
      end
      vfra_pkg::S_QMARK: if (eng_done) state_nxt = vfra_pkg::S_VMARK;
      vfra_pkg::S_VMARK: if (eng_done) state_nxt = vfra_pkg::S_QCOUNT;
      vfra_pkg::S_QCOUNT: begin
        if (eng_done) begin
          qfree_nxt = e_cnt;
          state_nxt = vfra_pkg::S_VCOUNT;
        end
      end
      vfra_pkg::S_VCOUNT: begin
        if (eng_done) begin
          vfree_nxt = e_cnt;
          state_nxt = vfra_pkg::S_OUT;
        end
      end
      vfra_pkg::S_OUT: begin
        if (!ov_r || out_rsp.ready) begin
          ov_nxt       = 1'b1;
          o_status_nxt = status_r;
          o_fq_nxt     = fq_r[7:0];
          o_fv_nxt     = fv_r[7:0];
          o_qf_nxt     = qfree_r;
          o_vf_nxt     = vfree_r;
          o_tot_nxt    = total_r;
          state_nxt    = vfra_pkg::S_IDLE;
        end
      end
      default: state_nxt = vfra_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) store[vidx] <= st_wr;
    st_rd_r <= store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_q_r <= 9'd256;
      total_v_r <= 9'd256;
      rsv_q_r   <= '0;
      rsv_v_r   <= '0;
      max_vfs_r <= 7'd64;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        vfra_pkg::CFG_TOTAL_Q: total_q_r <= cfg_wdata;
        vfra_pkg::CFG_TOTAL_V: total_v_r <= cfg_wdata;
        vfra_pkg::CFG_RSV_Q:   rsv_q_r   <= cfg_wdata;
        vfra_pkg::CFG_RSV_V:   rsv_v_r   <= cfg_wdata;
        vfra_pkg::CFG_MAX_VFS: max_vfs_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= vfra_pkg::S_IDLE;
      total_r   <= '0;
      present_r <= '0;
      issued_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      present_r <= present_nxt;
      issued_r  <= issued_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    vf_r       <= vf_nxt;
    nq_r       <= nq_nxt;
    nv_r       <= nv_nxt;
    status_r   <= status_nxt;
    fq_r       <= fq_nxt;
    fv_r       <= fv_nxt;
    qfree_r    <= qfree_nxt;
    vfree_r    <= vfree_nxt;
    o_status_r <= o_status_nxt;
    o_fq_r     <= o_fq_nxt;
    o_fv_r     <= o_fv_nxt;
    o_qf_r     <= o_qf_nxt;
    o_vf_r     <= o_vf_nxt;
    o_tot_r    <= o_tot_nxt;
  end

endmodule
`default_nettype wire

// ----- hdl/vfra_engine.sv -----
`default_nettype none
// Bitmap engine: both busy maps, one scan/mark datapath shared between them.
module vfra_engine #(
  parameter int QUEUE_POOL  = 256,
  parameter int VECTOR_POOL = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire vfra_pkg::eng_cmd_t          cmd,
  input  wire logic [vfra_pkg::CNT_W-1:0]  used,
  input  wire logic [vfra_pkg::CNT_W-1:0]  reserved,
  input  wire logic [vfra_pkg::CNT_W-1:0]  len,
  input  wire logic [vfra_pkg::CNT_W-1:0]  start_idx,
  output logic                             rdy,
  output logic                             done,
  output logic                             found,
  output logic [vfra_pkg::CNT_W-1:0]       res_idx,
  output logic [vfra_pkg::CNT_W-1:0]       res_cnt
);

  localparam int QAW  = (QUEUE_POOL > 1) ? $clog2(QUEUE_POOL) : 1;
  localparam int VAW  = (VECTOR_POOL > 1) ? $clog2(VECTOR_POOL) : 1;
  localparam int MAXP = (QUEUE_POOL > VECTOR_POOL) ? QUEUE_POOL : VECTOR_POOL;
  localparam int MAW  = $clog2(MAXP);
  localparam int W    = vfra_pkg::CNT_W;

  logic qmem [QUEUE_POOL];
  logic vmem [VECTOR_POOL];
  logic q_rd_r, v_rd_r;

  vfra_pkg::eng_state_t state_r, state_nxt;
  logic [MAW-1:0] clr_r, clr_nxt;
  vfra_pkg::eng_op_t op_r, op_nxt;
  logic pool_r, pool_nxt, val_r, val_nxt;
  logic [W-1:0] used_r, used_nxt, res_r, res_nxt, len_r, len_nxt;
  logic [W-1:0] ip_r, ip_nxt, end_r, end_nxt, pidx_r, pidx_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic pv_r, pv_nxt;
  logic done_r, done_nxt, found_r, found_nxt;
  logic [W-1:0] ridx_r, ridx_nxt, rcnt_r, rcnt_nxt;

  logic q_we, v_we, wdata;
  logic [QAW-1:0] q_addr;
  logic [VAW-1:0] v_addr;
  logic bit_rd, is_free, last;
  logic [W-1:0] acc_inc;

  assign rdy     = (state_r == vfra_pkg::E_IDLE);
  assign done    = done_r;
  assign found   = found_r;
  assign res_idx = ridx_r;
  assign res_cnt = rcnt_r;

  assign bit_rd  = (pool_r == vfra_pkg::POOL_V) ? v_rd_r : q_rd_r;
  assign is_free = (pidx_r >= res_r) && !bit_rd;
  assign last    = (pidx_r == used_r - W'(1));
  assign acc_inc = is_free ? acc_r + W'(1) : acc_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    pool_nxt  = pool_r;
    val_nxt   = val_r;
    used_nxt  = used_r;
    res_nxt   = res_r;
    len_nxt   = len_r;
    ip_nxt    = ip_r;
    end_nxt   = end_r;
    pidx_nxt  = pidx_r;
    acc_nxt   = acc_r;
    pv_nxt    = 1'b0;
    done_nxt  = 1'b0;
    found_nxt = found_r;
    ridx_nxt  = ridx_r;
    rcnt_nxt  = rcnt_r;
    q_we      = 1'b0;
    v_we      = 1'b0;
    wdata     = val_r;
    q_addr    = QAW'(ip_r);
    v_addr    = VAW'(ip_r);
    case (state_r)
      vfra_pkg::E_CLEAR: begin
        q_addr = QAW'(clr_r);
        v_addr = VAW'(clr_r);
        wdata  = 1'b0;
        q_we   = (32'(clr_r) < QUEUE_POOL);
        v_we   = (32'(clr_r) < VECTOR_POOL);
        clr_nxt = clr_r + MAW'(1);
        if (clr_r == MAW'(MAXP - 1)) state_nxt = vfra_pkg::E_IDLE;
      end
      vfra_pkg::E_IDLE: begin
        if (start) begin
          op_nxt   = cmd.op;
          pool_nxt = cmd.pool;
          val_nxt  = cmd.val;
          used_nxt = used;
          res_nxt  = reserved;
          len_nxt  = len;
          ip_nxt   = (cmd.op == vfra_pkg::OP_MARK) ? start_idx : '0;
          end_nxt  = start_idx + len;
          acc_nxt  = '0;
          found_nxt = 1'b0;
          rcnt_nxt  = '0;
          case (cmd.op)
            vfra_pkg::OP_FIND: begin
              if (len == '0 || len > used) done_nxt = 1'b1;
              else state_nxt = vfra_pkg::E_SCAN;
            end
            vfra_pkg::OP_COUNT: begin
              if (used == '0) done_nxt = 1'b1;
              else state_nxt = vfra_pkg::E_SCAN;
            end
            vfra_pkg::OP_MARK: begin
              if (len == '0) done_nxt = 1'b1;
              else state_nxt = vfra_pkg::E_MARK;
            end
            default: done_nxt = 1'b1;
          endcase
        end
      end
      vfra_pkg::E_SCAN: begin
        // read is issued in the cycle before the run tracker checks its bit
        if (ip_r < used_r) begin
          pv_nxt   = 1'b1;
          pidx_nxt = ip_r;
          ip_nxt   = ip_r + W'(1);
        end
        if (pv_r) begin
          if (op_r == vfra_pkg::OP_FIND) begin
            acc_nxt = is_free ? acc_r + W'(1) : '0;
            if (is_free && (acc_r + W'(1) == len_r)) begin
              done_nxt  = 1'b1;
              found_nxt = 1'b1;
              ridx_nxt  = pidx_r + W'(1) - len_r;
              state_nxt = vfra_pkg::E_IDLE;
            end else if (last) begin
              done_nxt  = 1'b1;
              state_nxt = vfra_pkg::E_IDLE;
            end
          end else begin
            acc_nxt = acc_inc;
            if (last) begin
              done_nxt  = 1'b1;
              rcnt_nxt  = acc_inc;
              state_nxt = vfra_pkg::E_IDLE;
            end
          end
        end
      end
      vfra_pkg::E_MARK: begin
        q_we   = (pool_r == vfra_pkg::POOL_Q);
        v_we   = (pool_r == vfra_pkg::POOL_V);
        ip_nxt = ip_r + W'(1);
        if (ip_r + W'(1) == end_r) begin
          done_nxt  = 1'b1;
          state_nxt = vfra_pkg::E_IDLE;
        end
      end
      default: state_nxt = vfra_pkg::E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we) qmem[q_addr] <= wdata;
    q_rd_r <= qmem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_addr] <= wdata;
    v_rd_r <= vmem[v_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vfra_pkg::E_CLEAR;
      clr_r   <= '0;
      pv_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pv_r    <= pv_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    pool_r  <= pool_nxt;
    val_r   <= val_nxt;
    used_r  <= used_nxt;
    res_r   <= res_nxt;
    len_r   <= len_nxt;
    ip_r    <= ip_nxt;
    end_r   <= end_nxt;
    pidx_r  <= pidx_nxt;
    acc_r   <= acc_nxt;
    found_r <= found_nxt;
    ridx_r  <= ridx_nxt;
    rcnt_r  <= rcnt_nxt;
  end

endmodule
`default_nettype wire
